// ----- rtl/tws_pkg.sv -----
// Shared types and constants for the three-wire serial master.
// No dependencies; used by tws_front, tws_back and three_wire_serial_master.
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

	localparam int BYTE_BITS_DEF = 8;
	localparam int CMD_DEPTH_DEF = 2;
	localparam int RES_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// Input transaction as seen on the push side.
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] addr;
		logic [7:0] wdata;
		logic       io_in;
	} in_t;

	// Result transaction as seen on the pop side.
	typedef struct packed {
		logic       ce;
		logic       sclk;
		logic       io_out;
		logic       io_drive;
		logic [7:0] rdata;
		logic       done_res;
		logic       busy_res;
	} out_t;

	// Classified tick handed from the front end to the sequencer.
	typedef struct packed {
		logic       start;
		logic       is_read;
		logic [7:0] addr;
		logic [7:0] wdata;
		logic       io_in;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/tws_fifo.sv -----
// Small register FIFO used as the command queue and the result queue.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tws_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tws_front.sv -----
// Front end: decode each incoming tick into a start or idle command and queue it.
// Depends on tws_pkg and tws_fifo.
`timescale 1ns / 1ps
`default_nettype none

module tws_front #(
	parameter int CMD_DEPTH = tws_pkg::CMD_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire tws_pkg::in_t item,
	output logic              full,
	input  wire logic         cmd_pop,
	output tws_pkg::cmd_t     cmd,
	output logic              cmd_empty
);

	tws_pkg::cmd_t cmd_in;

	// Unused op code counts as an idle tick.
	always_comb begin
		cmd_in.addr    = item.addr;
		cmd_in.wdata   = item.wdata;
		cmd_in.io_in   = item.io_in;
		cmd_in.start   = 1'b0;
		cmd_in.is_read = 1'b0;
		case (item.op)
			tws_pkg::OP_WRITE: begin
				cmd_in.start = 1'b1;
			end
			tws_pkg::OP_READ: begin
				cmd_in.start   = 1'b1;
				cmd_in.is_read = 1'b1;
			end
			default: begin
				cmd_in.start = 1'b0;
			end
		endcase
	end

	tws_fifo #(
		.WIDTH ($bits(tws_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

endmodule

`default_nettype wire

// ----- rtl/tws_back.sv -----
// Back end: the bit sequencer, one phase per command, producing one result each.
// Depends on tws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tws_back #(
	parameter int BYTE_BITS = tws_pkg::BYTE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire tws_pkg::cmd_t cmd,
	output tws_pkg::out_t      result
);

	localparam int PHASE_W = $clog2(4 * BYTE_BITS + 4);
	localparam int SEL_W   = $clog2(2 * BYTE_BITS);
	localparam int EXT_W   = (BYTE_BITS > 8) ? BYTE_BITS : 8;
	localparam logic [PHASE_W-1:0] END_T   = PHASE_W'(4 * BYTE_BITS);
	localparam logic [PHASE_W-1:0] RD_BITS = PHASE_W'(2 * BYTE_BITS);

	logic [PHASE_W-1:0]     phase_q, phase_n, t;
	logic [2*BYTE_BITS-1:0] shift_q, shift_eff;
	logic [BYTE_BITS-1:0]   acc_q, acc_eff, acc_n;
	logic [BYTE_BITS-1:0]   last_q, last_n;
	logic                   is_read_q, is_read_eff;
	logic                   busy_q, busy_eff, busy_n;
	logic                   ce_q, sclk_q, io_q, drv_q;
	logic                   ce_n, sclk_n, io_n, drv_n;
	logic                   done;
	logic                   start_now;
	logic [EXT_W-1:0]       addr_ext, wdata_ext, last_ext;
	logic [BYTE_BITS-1:0]   addr_b, wdata_b;
	logic [PHASE_W-1:0]     drive_end, rd_off;

	assign addr_ext  = EXT_W'(cmd.addr);
	assign wdata_ext = EXT_W'(cmd.wdata);
	assign addr_b    = addr_ext[BYTE_BITS-1:0];
	assign wdata_b   = wdata_ext[BYTE_BITS-1:0];
	assign start_now = !busy_q && cmd.start;

	always_comb begin
		if (start_now) begin
			is_read_eff = cmd.is_read;
			shift_eff   = cmd.is_read ? {{BYTE_BITS{1'b0}}, addr_b} : {wdata_b, addr_b};
			acc_eff     = '0;
			t           = '0;
			busy_eff    = 1'b1;
		end else begin
			is_read_eff = is_read_q;
			shift_eff   = shift_q;
			acc_eff     = acc_q;
			t           = phase_q;
			busy_eff    = busy_q;
		end
		drive_end = is_read_eff ? RD_BITS : END_T;
		rd_off    = t - RD_BITS;
		ce_n      = ce_q;
		sclk_n    = sclk_q;
		io_n      = io_q;
		drv_n     = drv_q;
		acc_n     = acc_eff;
		done      = 1'b0;
		if (busy_eff) begin
			if (t < drive_end) begin
				ce_n   = 1'b1;
				sclk_n = t[0];
				io_n   = shift_eff[t[SEL_W:1]];
				drv_n  = 1'b1;
			end else if (t < END_T) begin
				// Read half: data wire released, sample on the low clock tick.
				ce_n   = 1'b1;
				sclk_n = t[0];
				io_n   = 1'b0;
				drv_n  = 1'b0;
				if (!t[0]) begin
					acc_n = acc_eff | (BYTE_BITS'(cmd.io_in) << rd_off[PHASE_W-1:1]);
				end
			end else if (t == END_T) begin
				ce_n   = 1'b0;
				sclk_n = 1'b0;
				if (is_read_eff) begin
					io_n  = 1'b0;
					drv_n = 1'b0;
				end else begin
					done = 1'b1;
				end
			end else if (t == END_T + 1'b1) begin
				ce_n   = 1'b0;
				sclk_n = 1'b1;
				io_n   = 1'b0;
				drv_n  = 1'b0;
			end else if (t == END_T + 2'd2) begin
				ce_n   = 1'b0;
				sclk_n = 1'b1;
				io_n   = 1'b0;
				drv_n  = 1'b1;
			end else begin
				ce_n   = 1'b0;
				sclk_n = 1'b1;
				io_n   = 1'b1;
				drv_n  = 1'b1;
				done   = 1'b1;
			end
		end
		busy_n  = busy_eff && !done;
		last_n  = (done && is_read_eff) ? acc_n : last_q;
		phase_n = done ? '0 : (busy_eff ? t + 1'b1 : t);
	end

	assign last_ext        = EXT_W'(last_n);
	assign result.ce       = ce_n;
	assign result.sclk     = sclk_n;
	assign result.io_out   = io_n;
	assign result.io_drive = drv_n;
	assign result.rdata    = last_ext[7:0];
	assign result.done_res = done;
	assign result.busy_res = busy_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			shift_q   <= '0;
			acc_q     <= '0;
			last_q    <= '0;
			is_read_q <= 1'b0;
			busy_q    <= 1'b0;
			ce_q      <= 1'b0;
			sclk_q    <= 1'b0;
			io_q      <= 1'b0;
			drv_q     <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			shift_q   <= shift_eff;
			acc_q     <= acc_n;
			last_q    <= last_n;
			is_read_q <= is_read_eff;
			busy_q    <= busy_n;
			ce_q      <= ce_n;
			sclk_q    <= sclk_n;
			io_q      <= io_n;
			drv_q     <= drv_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/three_wire_serial_master.sv -----
// Three-wire serial master (chip enable, serial clock, data), LSB first.
// Usage:
//   Each input transaction is one half-bit tick: op selects idle, start write
//   or start read; addr, wdata and the sampled data-wire level io_in ride along.
//   Push a transaction when full is low. Every transaction yields exactly one
//   result transaction: pin levels (ce, sclk, io_out, io_drive), the last read
//   byte, done_res and busy_res. Take it with pop while empty is low.
//   A write spends 4*BYTE_BITS+1 ticks, a read 4*BYTE_BITS+4 ticks; a start
//   arriving while a transaction is running, or on its done tick, is dropped.
// Latency and throughput:
//   A result passes through the registered command queue and result queue before it can be popped. The back-end
//   sequencer steps one phase per cycle whenever a tick is queued and the result queue has room, which sets the
//   sustained rate of one transaction per cycle while the consumer pops every cycle.
// Reset:
//   arst_n clears both queues, the sequencer (idle, not busy) and all pin
//   levels and the read byte to zero.
// Stalls:
//   When pop stays low the result queue fills and the sequencer holds; the
//   command queue then fills and full rises. Nothing is dropped or reordered.
// Depends on tws_pkg, tws_fifo, tws_front and tws_back.
`timescale 1ns / 1ps
`default_nettype none

module three_wire_serial_master #(
	parameter int BYTE_BITS = tws_pkg::BYTE_BITS_DEF,
	parameter int CMD_DEPTH = tws_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH = tws_pkg::RES_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire tws_pkg::in_t item,
	output logic              full,
	input  wire logic         pop,
	output tws_pkg::out_t     result,
	output logic              empty
);

	tws_pkg::cmd_t cmd;
	tws_pkg::out_t seq_result;
	logic          cmd_empty;
	logic          res_full;
	logic          step;

	// Advance the sequencer whenever a tick is waiting and there is room for its result.
	assign step = !cmd_empty && !res_full;

	tws_front #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_pop   (step),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	tws_back #(
		.BYTE_BITS (BYTE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd),
		.result (seq_result)
	);

	// Hold finished results until the consumer takes them.
	tws_fifo #(
		.WIDTH ($bits(tws_pkg::out_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.wdata  (seq_result),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire
